// ----- hdl/pit_pkg.sv -----
// Shared types and constants for the point-in-triangle test.
package pit_pkg;

  // Orientation of a point against one directed triangle edge
  typedef enum logic [1:0] {
    ORI_ZERO = 2'd0,
    ORI_POS  = 2'd1,
    ORI_NEG  = 2'd2
  } orient_t;

  // Register stages inside one edge unit: differences, products, compare
  localparam int unsigned EDGE_STAGES = 3;

endpackage

// ----- hdl/pit_edge.sv -----
// Three-stage orientation unit for one directed edge s->e against query point q.
module pit_edge
  import pit_pkg::*;
#(
  parameter int unsigned COORD_BITS = 15
) (
  input  logic                         clk,
  input  logic signed [COORD_BITS-1:0] s_x,
  input  logic signed [COORD_BITS-1:0] s_y,
  input  logic signed [COORD_BITS-1:0] e_x,
  input  logic signed [COORD_BITS-1:0] e_y,
  input  logic signed [COORD_BITS-1:0] q_x,
  input  logic signed [COORD_BITS-1:0] q_y,
  output orient_t                      orient
);

  localparam int unsigned DW = COORD_BITS + 1;
  localparam int unsigned PW = 2 * DW;

  // Stage 1: edge and point differences
  logic signed [DW-1:0] ux_r, uy_r, vx_r, vy_r;
  logic signed [DW-1:0] ux_nxt, uy_nxt, vx_nxt, vy_nxt;

  // Stage 2: cross terms, squares, behind flag
  logic signed [PW-1:0] l_r, r_r, l_nxt, r_nxt;
  logic signed [PW-1:0] sq_ux, sq_uy, sq_vx, sq_vy;
  logic        [PW-1:0] ux2_r, uy2_r, vx2_r, vy2_r;
  logic                 behind_r, behind_nxt;

  // Stage 3: orientation code
  logic        [PW-1:0] len_u, len_v;
  orient_t              orient_r, orient_nxt;

  always_comb begin
    ux_nxt = $signed({e_x[COORD_BITS-1], e_x}) - $signed({s_x[COORD_BITS-1], s_x});
    uy_nxt = $signed({e_y[COORD_BITS-1], e_y}) - $signed({s_y[COORD_BITS-1], s_y});
    vx_nxt = $signed({q_x[COORD_BITS-1], q_x}) - $signed({s_x[COORD_BITS-1], s_x});
    vy_nxt = $signed({q_y[COORD_BITS-1], q_y}) - $signed({s_y[COORD_BITS-1], s_y});
  end

  always_comb begin
    l_nxt = PW'(ux_r) * PW'(vy_r);
    r_nxt = PW'(uy_r) * PW'(vx_r);
    sq_ux = PW'(ux_r) * PW'(ux_r);
    sq_uy = PW'(uy_r) * PW'(uy_r);
    sq_vx = PW'(vx_r) * PW'(vx_r);
    sq_vy = PW'(vy_r) * PW'(vy_r);
    // A negative product means both factors nonzero and of opposite sign
    behind_nxt = ((ux_r != '0) && (vx_r != '0) && (ux_r[DW-1] != vx_r[DW-1])) ||
                 ((uy_r != '0) && (vy_r != '0) && (uy_r[DW-1] != vy_r[DW-1]));
  end

  always_comb begin
    len_u = ux2_r + uy2_r;
    len_v = vx2_r + vy2_r;
    if (l_r > r_r) begin
      orient_nxt = ORI_POS;
    end else if (l_r < r_r) begin
      orient_nxt = ORI_NEG;
    end else if (behind_r) begin
      orient_nxt = ORI_NEG;
    end else if (len_u < len_v) begin
      orient_nxt = ORI_POS;
    end else begin
      orient_nxt = ORI_ZERO;
    end
  end

  always_ff @(posedge clk) begin
    ux_r     <= ux_nxt;
    uy_r     <= uy_nxt;
    vx_r     <= vx_nxt;
    vy_r     <= vy_nxt;
    l_r      <= l_nxt;
    r_r      <= r_nxt;
    ux2_r    <= $unsigned(sq_ux);
    uy2_r    <= $unsigned(sq_uy);
    vx2_r    <= $unsigned(sq_vx);
    vy2_r    <= $unsigned(sq_vy);
    behind_r <= behind_nxt;
    orient_r <= orient_nxt;
  end

  assign orient = orient_r;

endmodule

// ----- hdl/point_in_triangle_test.sv -----
// Point-in-triangle test: one query per clock, with a pipelined, registered result.
// A query is taken on every clock edge where start is high; busy is always low
// because the pipeline never stalls. The answer appears on out_inside_res with
// out_valid high for exactly one cycle, after the four register stages below,
// in query order. The four register stages are: differences plus bounding
// prefilter, the six products per edge, the orientation compares, and the
// final all-same-sign check. Coordinates are COORD_BITS-bit two's complement.
module point_in_triangle_test
  import pit_pkg::*;
#(
  parameter int unsigned COORD_BITS = 15
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [COORD_BITS-1:0] in_point_x,
  input  logic signed [COORD_BITS-1:0] in_point_y,
  input  logic signed [COORD_BITS-1:0] in_vertex_a_x,
  input  logic signed [COORD_BITS-1:0] in_vertex_a_y,
  input  logic signed [COORD_BITS-1:0] in_vertex_b_x,
  input  logic signed [COORD_BITS-1:0] in_vertex_b_y,
  input  logic signed [COORD_BITS-1:0] in_vertex_c_x,
  input  logic signed [COORD_BITS-1:0] in_vertex_c_y,
  output logic                         out_valid,
  output logic                         out_inside_res
);

  logic                   take;
  logic                   left, right, up, down;
  logic                   pass_nxt;
  logic [EDGE_STAGES-1:0] valid_r, pass_r;
  logic                   out_valid_r, out_inside_res_r;
  logic                   inside_nxt;
  orient_t                ori_ab, ori_bc, ori_ca;

  assign busy = 1'b0;
  assign take = start && !busy;

  // Bounding prefilter: vertices must straddle the point on both axes
  always_comb begin
    left  = (in_vertex_a_x < in_point_x) || (in_vertex_b_x < in_point_x) ||
            (in_vertex_c_x < in_point_x);
    right = (in_vertex_a_x >= in_point_x) || (in_vertex_b_x >= in_point_x) ||
            (in_vertex_c_x >= in_point_x);
    up    = (in_vertex_a_y < in_point_y) || (in_vertex_b_y < in_point_y) ||
            (in_vertex_c_y < in_point_y);
    down  = (in_vertex_a_y >= in_point_y) || (in_vertex_b_y >= in_point_y) ||
            (in_vertex_c_y >= in_point_y);
    pass_nxt = left && right && up && down;
  end

  pit_edge #(.COORD_BITS(COORD_BITS)) u_edge_ab (
    .clk    (clk),
    .s_x    (in_vertex_a_x),
    .s_y    (in_vertex_a_y),
    .e_x    (in_vertex_b_x),
    .e_y    (in_vertex_b_y),
    .q_x    (in_point_x),
    .q_y    (in_point_y),
    .orient (ori_ab)
  );

  pit_edge #(.COORD_BITS(COORD_BITS)) u_edge_bc (
    .clk    (clk),
    .s_x    (in_vertex_b_x),
    .s_y    (in_vertex_b_y),
    .e_x    (in_vertex_c_x),
    .e_y    (in_vertex_c_y),
    .q_x    (in_point_x),
    .q_y    (in_point_y),
    .orient (ori_bc)
  );

  pit_edge #(.COORD_BITS(COORD_BITS)) u_edge_ca (
    .clk    (clk),
    .s_x    (in_vertex_c_x),
    .s_y    (in_vertex_c_y),
    .e_x    (in_vertex_a_x),
    .e_y    (in_vertex_a_y),
    .q_x    (in_point_x),
    .q_y    (in_point_y),
    .orient (ori_ca)
  );

  // Inside when the prefilter passed and all three orientations agree and are nonzero
  always_comb begin
    inside_nxt = pass_r[EDGE_STAGES-1] &&
                 (((ori_ab == ORI_POS) && (ori_bc == ORI_POS) && (ori_ca == ORI_POS)) ||
                  ((ori_ab == ORI_NEG) && (ori_bc == ORI_NEG) && (ori_ca == ORI_NEG)));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      valid_r     <= {valid_r[EDGE_STAGES-2:0], take};
      out_valid_r <= valid_r[EDGE_STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    pass_r           <= {pass_r[EDGE_STAGES-2:0], pass_nxt};
    out_inside_res_r <= inside_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_inside_res = out_inside_res_r;

endmodule
